### src/rcfs_pkg.sv
// Shared types, opcodes, register indexes and reset constants for the
// RC control / failsafe supervisor. No dependencies.
`timescale 1ns / 1ps

package rcfs_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned IDLE_W     = 17;

    // opcodes
    localparam logic [2:0] OP_CONTROL = 3'd0;
    localparam logic [2:0] OP_ARM     = 3'd1;
    localparam logic [2:0] OP_DISARM  = 3'd2;
    localparam logic [2:0] OP_TRIM    = 3'd3;
    localparam logic [2:0] OP_TICK    = 3'd4;
    localparam logic [2:0] OP_BATTERY = 3'd5;

    // ack codes
    localparam logic [1:0] ACK_NONE     = 2'd0;
    localparam logic [1:0] ACK_ARMED    = 2'd1;
    localparam logic [1:0] ACK_DISARMED = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FS_TIMEOUT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_BATT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CRIT_BATT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FS_AILERON   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FS_ELEVATOR  = 3'd4;

    // reset values
    localparam logic [15:0] RST_FS_TIMEOUT  = 16'd1000;
    localparam logic [9:0]  RST_LOW_BATT    = 10'd478;
    localparam logic [9:0]  RST_CRIT_BATT   = 10'd444;
    localparam logic [7:0]  RST_FS_AILERON  = 8'd90;
    localparam logic [7:0]  RST_FS_ELEVATOR = 8'd90;
    localparam logic signed [15:0] RST_SURFACE_CMD = 16'sd90;

    localparam logic [7:0]  SERVO_MAX = 8'd180;
    localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};
    localparam logic signed [7:0] TRIM_MIN = 8'sh80;
    localparam logic signed [7:0] TRIM_MAX = 8'sh7F;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [15:0] throttle_value;
        logic               throttle_present;
        logic signed [15:0] aileron_value;
        logic               aileron_present;
        logic signed [15:0] elevator_value;
        logic               elevator_present;
        logic [9:0]         battery_sample;
    } t_in_item;

    typedef struct packed {
        logic [7:0] throttle_out;
        logic [7:0] aileron_out;
        logic [7:0] elevator_out;
        logic       armed;
        logic [1:0] ack_code;
        logic       low_battery_alert;
        logic       failsafe_active;
        logic [9:0] battery_level;
    } t_out_item;

    typedef struct packed {
        logic [15:0] fs_timeout;
        logic [9:0]  low_batt;
        logic [9:0]  crit_batt;
        logic [7:0]  fs_aileron;
        logic [7:0]  fs_elevator;
    } t_cfg;

    // clamp a 17-bit signed value to the servo range 0..180
    function automatic logic [7:0] clamp_servo(input logic signed [16:0] v);
        if (v < 17'sd0) begin
            return 8'd0;
        end else if (v > $signed({9'd0, SERVO_MAX})) begin
            return SERVO_MAX;
        end else begin
            return v[7:0];
        end
    endfunction

    // saturate a 16-bit signed trim request to -128..127
    function automatic logic signed [7:0] sat_trim(input logic signed [15:0] v);
        if (v < -16'sd128) begin
            return TRIM_MIN;
        end else if (v > 16'sd127) begin
            return TRIM_MAX;
        end else begin
            return v[7:0];
        end
    endfunction

endpackage

### src/rcfs_cfg_regs.sv
// Configuration register file for the supervisor.
// Depends on rcfs_pkg.
`timescale 1ns / 1ps

module rcfs_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rcfs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rcfs_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output rcfs_pkg::t_cfg                   o_cfg
);
    import rcfs_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fs_timeout  <= RST_FS_TIMEOUT;
            r_cfg.low_batt    <= RST_LOW_BATT;
            r_cfg.crit_batt   <= RST_CRIT_BATT;
            r_cfg.fs_aileron  <= RST_FS_AILERON;
            r_cfg.fs_elevator <= RST_FS_ELEVATOR;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FS_TIMEOUT:  r_cfg.fs_timeout  <= i_cfg_wdata;
                REG_LOW_BATT:    r_cfg.low_batt    <= i_cfg_wdata[9:0];
                REG_CRIT_BATT:   r_cfg.crit_batt   <= i_cfg_wdata[9:0];
                REG_FS_AILERON:  r_cfg.fs_aileron  <= i_cfg_wdata[7:0];
                REG_FS_ELEVATOR: r_cfg.fs_elevator <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### src/rcfs_engine.sv
// Supervisor state (arm flag, commands, trims, idle counter, battery) and
// the single-pass update that turns one item into its status result.
// Depends on rcfs_pkg.
`timescale 1ns / 1ps

module rcfs_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  rcfs_pkg::t_in_item   i_item,
    input  rcfs_pkg::t_cfg       i_cfg,
    output rcfs_pkg::t_out_item  o_result
);
    import rcfs_pkg::*;

    logic                     r_armed, n_armed;
    logic [7:0]               r_throttle, n_throttle;
    logic signed [15:0]       r_ail_cmd, n_ail_cmd;
    logic signed [15:0]       r_elv_cmd, n_elv_cmd;
    logic signed [7:0]        r_ail_trim, n_ail_trim;
    logic signed [7:0]        r_elv_trim, n_elv_trim;
    logic [IDLE_W-1:0]        r_idle, n_idle;
    logic [9:0]               r_batt, n_batt;

    logic [1:0]               w_ack;
    logic                     w_alert;
    logic                     w_fs;
    logic signed [15:0]       w_thr_req;
    logic signed [16:0]       w_ail_sum;
    logic signed [16:0]       w_elv_sum;

    always_comb begin
        n_armed    = r_armed;
        n_throttle = r_throttle;
        n_ail_cmd  = r_ail_cmd;
        n_elv_cmd  = r_elv_cmd;
        n_ail_trim = r_ail_trim;
        n_elv_trim = r_elv_trim;
        n_idle     = r_idle;
        n_batt     = r_batt;
        w_ack      = ACK_NONE;
        w_alert    = 1'b0;
        w_fs       = 1'b0;
        w_thr_req  = i_item.throttle_present ? i_item.throttle_value
                                             : $signed({8'd0, r_throttle});

        // any command restarts the idle count
        if (i_item.opcode <= OP_TRIM) begin
            n_idle = '0;
        end

        case (i_item.opcode)
            OP_CONTROL: begin
                n_throttle = r_armed ? clamp_servo({w_thr_req[15], w_thr_req}) : 8'd0;
                if (i_item.aileron_present) n_ail_cmd = i_item.aileron_value;
                if (i_item.elevator_present) n_elv_cmd = i_item.elevator_value;
            end
            OP_ARM: begin
                if (!r_armed) begin
                    n_armed = 1'b1;
                    w_ack   = ACK_ARMED;
                end
            end
            OP_DISARM: begin
                if (r_armed) begin
                    n_armed    = 1'b0;
                    n_throttle = 8'd0;
                    w_ack      = ACK_DISARMED;
                end
            end
            OP_TRIM: begin
                if (i_item.aileron_present) n_ail_trim = sat_trim(i_item.aileron_value);
                if (i_item.elevator_present) n_elv_trim = sat_trim(i_item.elevator_value);
            end
            OP_TICK: begin
                if (r_idle != IDLE_MAX) begin
                    n_idle = r_idle + IDLE_W'(1);
                end
                if (n_idle > {1'b0, i_cfg.fs_timeout}) begin
                    n_throttle = 8'd0;
                    n_ail_cmd  = $signed({8'd0, i_cfg.fs_aileron});
                    n_elv_cmd  = $signed({8'd0, i_cfg.fs_elevator});
                    n_armed    = 1'b0;
                    w_fs       = 1'b1;
                end
            end
            OP_BATTERY: begin
                n_batt = i_item.battery_sample;
                if (i_item.battery_sample < i_cfg.low_batt) begin
                    w_alert = 1'b1;
                    if (i_item.battery_sample < i_cfg.crit_batt && r_armed) begin
                        n_armed    = 1'b0;
                        n_throttle = 8'd0;
                        w_ack      = ACK_DISARMED;
                    end
                end
            end
            default: ;
        endcase
    end

    assign w_ail_sum = {n_ail_cmd[15], n_ail_cmd} + {{9{n_ail_trim[7]}}, n_ail_trim};
    assign w_elv_sum = {n_elv_cmd[15], n_elv_cmd} + {{9{n_elv_trim[7]}}, n_elv_trim};

    always_comb begin
        o_result.throttle_out      = n_armed ? n_throttle : 8'd0;
        o_result.aileron_out       = clamp_servo(w_ail_sum);
        o_result.elevator_out      = clamp_servo(w_elv_sum);
        o_result.armed             = n_armed;
        o_result.ack_code          = w_ack;
        o_result.low_battery_alert = w_alert;
        o_result.failsafe_active   = w_fs;
        o_result.battery_level     = n_batt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed    <= 1'b0;
            r_throttle <= 8'd0;
            r_ail_cmd  <= RST_SURFACE_CMD;
            r_elv_cmd  <= RST_SURFACE_CMD;
            r_ail_trim <= 8'sd0;
            r_elv_trim <= 8'sd0;
            r_idle     <= '0;
            r_batt     <= 10'd0;
        end else if (i_en) begin
            r_armed    <= n_armed;
            r_throttle <= n_throttle;
            r_ail_cmd  <= n_ail_cmd;
            r_elv_cmd  <= n_elv_cmd;
            r_ail_trim <= n_ail_trim;
            r_elv_trim <= n_elv_trim;
            r_idle     <= n_idle;
            r_batt     <= n_batt;
        end
    end

endmodule

### src/rc_control_failsafe_supervisor.sv
// Top level of the RC control / failsafe supervisor: input register,
// result register and handshake. Depends on rcfs_pkg, rcfs_cfg_regs, rcfs_engine.
`timescale 1ns / 1ps

// Usage
//   Input channel: i_in_valid / o_in_stall carry one item (command, tick or
//   battery sample) in i_in_item. Output channel: o_out_valid / i_out_stall
//   carry exactly one status item per input item, in order.
//   Config port: i_cfg_we writes i_cfg_wdata to register i_cfg_index
//   (0 timeout, 1 low battery, 2 critical battery, 3/4 failsafe positions);
//   write only while no item is in flight.
//   An accepted item is first registered in the input register, then processed
//   into the result register; its result is valid from then on.
//   Throughput: one item per cycle when not stalled; the state update for an item
//   is a single combinational pass between the input and result registers.
//   Stall: while the result register is held, the input register holds its
//   item and o_in_stall rises once that register is full as well.
//   Reset: synchronous, active low; clears both valid bits, sets config
//   registers to their defaults and the state to disarmed, surfaces at 90,
//   zero trim, zero idle count and zero battery level.
module rc_control_failsafe_supervisor (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  rcfs_pkg::t_in_item               i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output rcfs_pkg::t_out_item              o_out_item,
    input  logic                             i_cfg_we,
    input  logic [rcfs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rcfs_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import rcfs_pkg::*;

    logic       r_in_valid;
    t_in_item   r_in_item;
    logic       r_out_valid;
    t_out_item  r_out_item;

    t_cfg       w_cfg;
    t_out_item  w_result;
    logic       w_out_free;
    logic       w_process;
    logic       w_in_free;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_process  = r_in_valid && w_out_free;
    assign w_in_free  = !r_in_valid || w_process;

    rcfs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    rcfs_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_process),
        .i_item   (r_in_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_free) r_in_valid <= i_in_valid;
            if (w_out_free) r_out_valid <= w_process;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_free && i_in_valid) r_in_item <= i_in_item;
        if (w_process) r_out_item <= w_result;
    end

    assign o_in_stall  = !w_in_free;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // stall only when the input register really holds an item
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with empty input register");

    // disarmed results never drive the motor
    a_disarmed_throttle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.armed) |-> (o_out_item.throttle_out == 8'd0))
        else $error("throttle nonzero while disarmed");

    // ack code agrees with the arm flag it reports
    a_ack_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_item.ack_code == ACK_NONE)
                      || (o_out_item.ack_code == ACK_ARMED && o_out_item.armed)
                      || (o_out_item.ack_code == ACK_DISARMED && !o_out_item.armed)))
        else $error("ack code inconsistent with armed flag");

    // a processed item lands in the result register on the next edge
    a_process_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_process |=> r_out_valid)
        else $error("processed item lost");

    // failsafe always leaves the block disarmed
    a_failsafe_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.failsafe_active) |-> !o_out_item.armed)
        else $error("failsafe result still armed");

endmodule
